FILE: rtl/hcps_pkg.sv
package hcps_pkg;

  localparam int FRAME_WIDTH  = 256;
  localparam int FRAME_HEIGHT = 256;
  localparam int LINE_ROWS    = 8;
  localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int PIPE_LAG     = 3 * FRAME_WIDTH + 3;

  localparam int CNT_W      = $clog2(FRAME_PIXELS + 1);
  localparam int COL_W      = $clog2(FRAME_WIDTH);
  localparam int ROW_W      = ($clog2(FRAME_HEIGHT) > 3) ? $clog2(FRAME_HEIGHT) : 3;
  localparam int CRD_W      = ((ROW_W > COL_W) ? ROW_W : COL_W) + 3;
  localparam int GRAY_DEPTH = LINE_ROWS * FRAME_WIDTH;
  localparam int GRAY_AW    = $clog2(GRAY_DEPTH);

  localparam logic [15:0] THRESH_RST = 16'd100;

  // sigma 1.5 and sigma 1.0 kernels, Q0.16
  localparam logic [13:0] K15_CORNER = 14'd6209;
  localparam logic [13:0] K15_EDGE   = 14'd7754;
  localparam logic [13:0] K15_CENTER = 14'd9684;
  localparam logic [13:0] K10_CORNER = 14'd4923;
  localparam logic [13:0] K10_EDGE   = 14'd8116;
  localparam logic [13:0] K10_CENTER = 14'd13381;

  // floor(s/3) for s <= 765 via reciprocal 683/2048
  function automatic logic [7:0] div3(input logic [9:0] s);
    logic [19:0] p;
    begin
      p = 20'(s) * 20'd683;
      return p[18:11];
    end
  endfunction

  // reflect without edge repeat: -1 -> 1, n -> n-2
  function automatic logic signed [CRD_W-1:0] mirror(input logic signed [CRD_W-1:0] v,
                                                     input logic signed [CRD_W-1:0] n);
    logic signed [CRD_W-1:0] m;
    begin
      m = (v < 0) ? -v : v;
      if (m >= n) m = (n <<< 1) - CRD_W'(2) - m;
      if (m < 0) m = '0;
      return m;
    end
  endfunction

  function automatic logic [13:0] k15_w(input logic [1:0] tr, input logic [1:0] tc);
    logic rc, cc;
    begin
      rc = (tr == 2'd1);
      cc = (tc == 2'd1);
      if (rc && cc) return K15_CENTER;
      else if (rc || cc) return K15_EDGE;
      else return K15_CORNER;
    end
  endfunction

  function automatic logic [13:0] k10_w(input logic [1:0] tr, input logic [1:0] tc);
    logic rc, cc;
    begin
      rc = (tr == 2'd1);
      cc = (tc == 2'd1);
      if (rc && cc) return K10_CENTER;
      else if (rc || cc) return K10_EDGE;
      else return K10_CORNER;
    end
  endfunction

endpackage

FILE: rtl/harris_corner_pixel_stream_top.sv
// Harris corner detector on a row-major RGB pixel stream, one frame at a time.
// Input channel: in_valid_i/in_stall_o with func_i, red_i, green_i, blue_i.
//   func_i = 0 is a pixel, func_i = 1 a flush request that drains the tail.
// Output channel: out_valid_o/out_stall_i with corner_o and frame_last_o.
// Config: cfg_we_i writes cfg_wdata_i into the corner threshold (reset 100);
//   write it only while the block is idle.
// The result for pixel k leaves with pixel k + 3*FRAME_WIDTH + 3; after the
// last pixel each flush request releases one pending result. frame_last_o
// marks the final pixel, after which a new frame starts.
// A request without a result leaves the block idle. One with a result on
// the frame border goes straight to the output register; an interior one
// is dominated by the gray line memory's single read port (225 reads for
// the 5x5 blur patch), then the gradient products and the det/trace test.
// Gray pixels live in an 8-row line memory (one read, one write port). Writes
// only happen in idle; read data is only used while blurring, so no clash.
// Reset clears counters, control and the output valid flag; memory contents
// are not cleared (every read hits a pixel written this frame).
// A stalled receiver holds the result; the block waits before loading the
// next one and stops taking requests meanwhile.
module harris_corner_pixel_stream_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        corner_o,
  output logic        frame_last_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int CW  = hcps_pkg::CNT_W;
  localparam int XW  = hcps_pkg::CRD_W;
  localparam int AW  = hcps_pkg::GRAY_AW;
  localparam int RW  = hcps_pkg::ROW_W;
  localparam int CLW = hcps_pkg::COL_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_BLUR   = 3'd1;
  localparam logic [2:0] S_BDRAIN = 3'd2;
  localparam logic [2:0] S_PROD   = 3'd3;
  localparam logic [2:0] S_DET1   = 3'd4;
  localparam logic [2:0] S_DET2   = 3'd5;
  localparam logic [2:0] S_DET3   = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [15:0]   thr_q;
  logic [CW-1:0] in_cnt_q, out_cnt_q;
  logic [RW-1:0] in_row_q, out_row_q;
  logic [CLW-1:0] in_col_q, out_col_q;

  // gray line memory
  logic [7:0]    gray_mem [hcps_pkg::GRAY_DEPTH];
  logic [7:0]    gray_rdata_q;
  logic [AW-1:0] gray_raddr, gray_waddr;
  logic          gray_we;

  logic          in_acc, is_data, ready, interior;
  logic [CW:0]   in_cnt_inc;

  // blur sweep counters
  logic [2:0] brow_q, bcol_q;
  logic [1:0] trow_q, tcol_q;
  logic [4:0] bidx_q;
  logic       issue_last;
  logic       p_vld_q, p_first_q, p_last_q;
  logic [13:0] p_w_q;
  logic [4:0]  p_bidx_q;
  logic [23:0] bacc_q, bacc_d, bacc_rnd;
  logic [7:0]  blur_q [25];
  logic signed [XW-1:0] gr, gc, mr, mc;

  // product phase
  logic [1:0] pr_q, pc_q;
  logic [2:0] pstep_q;
  logic [4:0] pbase, bsel;
  logic [7:0] bl_q, brt_q, bu_q, bd_q, blur_rd;
  logic signed [XW-1:0] cx, cy;
  logic       xv, yv;
  logic signed [8:0]  ix, iy;
  logic signed [17:0] pxx_q, pyy_q, pxy_q;
  logic signed [32:0] wxx_q, wyy_q, wxy_q;
  logic signed [14:0] w10;
  logic signed [35:0] axx_q, ayy_q, axy_q;
  logic signed [35:0] rxx, ryy, rxy;
  logic signed [17:0] sxx, syy, sxy;

  // det / trace
  logic signed [18:0] tr_q;
  logic signed [35:0] m1_q, m2_q;
  logic signed [36:0] det_q;
  logic [36:0] rhs_q;
  logic [37:0] lhs;
  logic        res_q;

  logic out_vld_q, out_corner_q, out_last_q, out_load, out_k_last;

  // ---------------- input side ----------------
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_data    = !func_i && (in_cnt_q < CW'(hcps_pkg::FRAME_PIXELS));
  assign gray_we    = in_acc && is_data;
  assign in_cnt_inc = (CW+1)'(in_cnt_q) + (CW+1)'(1);
  assign gray_waddr = AW'(32'(in_row_q[2:0]) * hcps_pkg::FRAME_WIDTH + 32'(in_col_q));

  always_comb begin
    if (is_data) begin
      ready = in_cnt_inc > ((CW+1)'(out_cnt_q) + (CW+1)'(hcps_pkg::PIPE_LAG));
    end else begin
      ready = (in_cnt_q == CW'(hcps_pkg::FRAME_PIXELS)) &&
              (out_cnt_q < CW'(hcps_pkg::FRAME_PIXELS));
    end
  end

  assign interior = (out_row_q != '0) && (out_row_q < RW'(hcps_pkg::FRAME_HEIGHT - 1)) &&
                    (out_col_q != '0) && (out_col_q < CLW'(hcps_pkg::FRAME_WIDTH - 1));

  // ---------------- gray memory ----------------
  assign gr = XW'(out_row_q) + XW'(brow_q) + XW'(trow_q) - XW'(3);
  assign gc = XW'(out_col_q) + XW'(bcol_q) + XW'(tcol_q) - XW'(3);
  assign mr = hcps_pkg::mirror(gr, XW'(hcps_pkg::FRAME_HEIGHT));
  assign mc = hcps_pkg::mirror(gc, XW'(hcps_pkg::FRAME_WIDTH));
  assign gray_raddr = AW'(32'(mr[2:0]) * hcps_pkg::FRAME_WIDTH + 32'(mc[CLW-1:0]));

  always_ff @(posedge clk_i) begin
    if (gray_we) begin
      gray_mem[gray_waddr] <= hcps_pkg::div3(10'(red_i) + 10'(green_i) + 10'(blue_i));
    end
    gray_rdata_q <= gray_mem[gray_raddr];
  end

  // ---------------- blur accumulate ----------------
  assign issue_last = (brow_q == 3'd4) && (bcol_q == 3'd4) &&
                      (trow_q == 2'd2) && (tcol_q == 2'd2);
  assign bacc_d   = (p_first_q ? 24'd0 : bacc_q) + 24'(p_w_q * gray_rdata_q);
  assign bacc_rnd = bacc_d + 24'd32768;

  always_ff @(posedge clk_i) begin
    p_w_q     <= hcps_pkg::k15_w(trow_q, tcol_q);
    p_first_q <= (trow_q == 2'd0) && (tcol_q == 2'd0);
    p_last_q  <= (trow_q == 2'd2) && (tcol_q == 2'd2);
    p_bidx_q  <= bidx_q;
    if (p_vld_q) begin
      bacc_q <= bacc_d;
      if (p_last_q) blur_q[p_bidx_q] <= bacc_rnd[23:16];
    end
  end

  // ---------------- gradient products ----------------
  assign pbase = 5'(pr_q) * 5'd5 + 5'(pc_q);
  always_comb begin
    case (pstep_q)
      3'd0:    bsel = pbase + 5'd5;
      3'd1:    bsel = pbase + 5'd7;
      3'd2:    bsel = pbase + 5'd1;
      3'd3:    bsel = pbase + 5'd11;
      default: bsel = pbase;
    endcase
  end
  assign blur_rd = blur_q[bsel];

  assign cx = XW'(out_col_q) + XW'(pc_q) - XW'(1);
  assign cy = XW'(out_row_q) + XW'(pr_q) - XW'(1);
  assign xv = (cx > 0) && (cx < XW'(hcps_pkg::FRAME_WIDTH - 1));
  assign yv = (cy > 0) && (cy < XW'(hcps_pkg::FRAME_HEIGHT - 1));
  assign ix = xv ? ($signed({1'b0, bl_q}) - $signed({1'b0, brt_q})) : 9'sd0;
  assign iy = yv ? ($signed({1'b0, bu_q}) - $signed({1'b0, bd_q})) : 9'sd0;
  assign w10 = $signed({1'b0, hcps_pkg::k10_w(pr_q, pc_q)});

  assign rxx = axx_q + 36'sd32768;
  assign ryy = ayy_q + 36'sd32768;
  assign rxy = axy_q + 36'sd32768;
  assign sxx = $signed(rxx[33:16]);
  assign syy = $signed(ryy[33:16]);
  assign sxy = $signed(rxy[33:16]);

  assign lhs = 38'({det_q[35:0], 1'b0}) + 38'(tr_q[17:0]);

  always_ff @(posedge clk_i) begin
    case (pstep_q)
      3'd0: bl_q  <= blur_rd;
      3'd1: brt_q <= blur_rd;
      3'd2: bu_q  <= blur_rd;
      3'd3: bd_q  <= blur_rd;
      default: ;
    endcase
    pxx_q <= ix * ix;
    pyy_q <= iy * iy;
    pxy_q <= ix * iy;
    wxx_q <= w10 * pxx_q;
    wyy_q <= w10 * pyy_q;
    wxy_q <= w10 * pxy_q;
    tr_q  <= 19'(sxx) + 19'(syy);
    m1_q  <= sxx * syy;
    m2_q  <= sxy * sxy;
    det_q <= 37'(m1_q) - 37'(m2_q);
    rhs_q <= 37'({1'b0, thr_q} + 17'd1) * 37'({tr_q[17:0], 1'b0});
  end

  // ---------------- output register ----------------
  assign out_load   = (state_q == S_OUT) && (!out_vld_q || !out_stall_i);
  assign out_k_last = (out_cnt_q == CW'(hcps_pkg::FRAME_PIXELS - 1));
  assign out_valid_o  = out_vld_q;
  assign corner_o     = out_corner_q;
  assign frame_last_o = out_last_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_corner_q <= res_q;
      out_last_q   <= out_k_last;
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && ready) state_d = interior ? S_BLUR : S_OUT;
      end
      S_BLUR:   if (issue_last) state_d = S_BDRAIN;
      S_BDRAIN: state_d = S_PROD;
      S_PROD: begin
        if (pstep_q == 3'd6 && pr_q == 2'd2 && pc_q == 2'd2) state_d = S_DET1;
      end
      S_DET1: state_d = S_DET2;
      S_DET2: state_d = S_DET3;
      S_DET3: state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      thr_q     <= hcps_pkg::THRESH_RST;
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      out_vld_q <= 1'b0;
      p_vld_q   <= 1'b0;
      brow_q    <= '0;
      bcol_q    <= '0;
      trow_q    <= '0;
      tcol_q    <= '0;
      bidx_q    <= '0;
      pr_q      <= '0;
      pc_q      <= '0;
      pstep_q   <= '0;
      axx_q     <= '0;
      ayy_q     <= '0;
      axy_q     <= '0;
      res_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      p_vld_q <= (state_q == S_BLUR);
      if (cfg_we_i) thr_q <= cfg_wdata_i;

      if (gray_we) begin
        in_cnt_q <= in_cnt_inc[CW-1:0];
        if (in_col_q == CLW'(hcps_pkg::FRAME_WIDTH - 1)) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + RW'(1);
        end else begin
          in_col_q <= in_col_q + CLW'(1);
        end
      end

      if (state_q == S_IDLE) begin
        brow_q  <= '0;
        bcol_q  <= '0;
        trow_q  <= '0;
        tcol_q  <= '0;
        bidx_q  <= '0;
        pr_q    <= '0;
        pc_q    <= '0;
        pstep_q <= '0;
        axx_q   <= '0;
        ayy_q   <= '0;
        axy_q   <= '0;
        res_q   <= 1'b0;
      end

      if (state_q == S_BLUR) begin
        if (tcol_q != 2'd2) begin
          tcol_q <= tcol_q + 2'd1;
        end else begin
          tcol_q <= '0;
          if (trow_q != 2'd2) begin
            trow_q <= trow_q + 2'd1;
          end else begin
            trow_q <= '0;
            bidx_q <= bidx_q + 5'd1;
            if (bcol_q != 3'd4) begin
              bcol_q <= bcol_q + 3'd1;
            end else begin
              bcol_q <= '0;
              brow_q <= brow_q + 3'd1;
            end
          end
        end
      end

      if (state_q == S_PROD) begin
        if (pstep_q == 3'd6) begin
          pstep_q <= '0;
          axx_q   <= axx_q + 36'(wxx_q);
          ayy_q   <= ayy_q + 36'(wyy_q);
          axy_q   <= axy_q + 36'(wxy_q);
          if (pc_q != 2'd2) begin
            pc_q <= pc_q + 2'd1;
          end else begin
            pc_q <= '0;
            pr_q <= pr_q + 2'd1;
          end
        end else begin
          pstep_q <= pstep_q + 3'd1;
        end
      end

      if (state_q == S_DET3) begin
        res_q <= (tr_q > 0) && (det_q > 0) && (lhs >= 38'(rhs_q));
      end

      if (out_load) begin
        out_vld_q <= 1'b1;
        if (out_k_last) begin
          out_cnt_q <= '0;
          in_cnt_q  <= '0;
          out_row_q <= '0;
          out_col_q <= '0;
          in_row_q  <= '0;
          in_col_q  <= '0;
        end else begin
          out_cnt_q <= out_cnt_q + CW'(1);
          if (out_col_q == CLW'(hcps_pkg::FRAME_WIDTH - 1)) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + RW'(1);
          end else begin
            out_col_q <= out_col_q + CLW'(1);
          end
        end
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_out_le_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q <= in_cnt_q)
    else $error("more results than pixels");

  a_in_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_cnt_q <= CW'(hcps_pkg::FRAME_PIXELS))
    else $error("input count past frame");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_k_last) |=> (in_cnt_q == '0 && out_cnt_q == '0))
    else $error("frame did not wrap after last result");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ready) |=> (state_q != S_IDLE))
    else $error("result-bearing request did not start work");
`endif

endmodule
